[design/vam_pkg.sv]
package vam_pkg;

  // Q1.14 value of +1.0.
  localparam int ONE_Q14 = 16384;

  // Square root units: radicand widths (root is half as wide).
  localparam int SQ1_RAD_W = 48;  // length: (x^2+y^2+z^2) << 16
  localparam int SQ2_RAD_W = 62;  // sine: |d x n|^2

  // Divider units, three lanes sharing one divisor.
  localparam int DIV_LANES  = 3;
  localparam int QUO_W      = 15;
  localparam int DIV1_NUM_W = 38;
  localparam int DIV1_DEN_W = 24;
  localparam int DIV2_NUM_W = 46;
  localparam int DIV2_DEN_W = 31;

  // The sine rounds to zero when |d x n|^2 is below 2^26 (Q28 squared).
  localparam int SIN_MIN_LOG2 = 26;

  typedef enum logic [1:0] {
    CFG_DIR_X = 2'd0,
    CFG_DIR_Y = 2'd1,
    CFG_DIR_Z = 2'd2
  } cfg_reg_t;

endpackage

[design/vam_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage (floor of the root).
module vam_sqrt_pipe #(
  parameter int RAD_W  = vam_pkg::SQ1_RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic                vld_r  [ROOT_W];
  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [RAD_W-1:0]    rad_r  [ROOT_W];
  logic [SIDE_W-1:0]   side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    // The remainder never exceeds twice the partial root, so its top bits
    // are zero before the next pair of radicand bits is brought down.
    always_comb begin
      rem_sh   = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
      trial    = {root_i, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_i[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
      side_r[k] <= side_i;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

[design/vam_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The true quotient must stay below 2^QUO_W.
module vam_div_pipe #(
  parameter int NUM_W  = vam_pkg::DIV1_NUM_W,
  parameter int DEN_W  = vam_pkg::DIV1_DEN_W,
  parameter int QUO_W  = vam_pkg::QUO_W,
  parameter int LANES  = vam_pkg::DIV_LANES,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [LANES-1:0][NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]              in_den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [LANES-1:0][QUO_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;

  logic                        vld_r  [QUO_W];
  logic [DEN_W-1:0]            den_r  [QUO_W];
  logic [LANES-1:0][NUM_W-1:0] rem_r  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_r  [QUO_W];
  logic [SIDE_W-1:0]           side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    logic                        vld_i;
    logic [DEN_W-1:0]            den_i;
    logic [LANES-1:0][NUM_W-1:0] rem_i;
    logic [LANES-1:0][NUM_W-1:0] rem_nxt;
    logic [LANES-1:0][QUO_W-1:0] quo_i;
    logic [LANES-1:0][QUO_W-1:0] quo_nxt;
    logic [SIDE_W-1:0]           side_i;
    logic [CMP_W-1:0]            dsh;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign den_i  = in_den;
      assign rem_i  = in_num;
      assign quo_i  = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign den_i  = den_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      dsh = CMP_W'(den_i) << BIT;
      for (int l = 0; l < LANES; l++) begin
        quo_nxt[l] = quo_i[l];
        if (CMP_W'(rem_i[l]) >= dsh) begin
          rem_nxt[l]      = NUM_W'(CMP_W'(rem_i[l]) - dsh);
          quo_nxt[l][BIT] = 1'b1;
        end else begin
          rem_nxt[l] = rem_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      den_r[k]  <= den_i;
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      side_r[k] <= side_i;
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

[design/vector_align_rotation_matrix.sv]
// Vector alignment rotation: for every 3-D vector transferred in, the block
// returns the vector's rounded Euclidean length and the Q1.14 rotation matrix
// (Rodrigues' formula) that turns the configured reference direction onto the
// normalized vector. The pipeline takes a new vector on every clock: busy is
// always low, so a transfer happens on each cycle with start high. The result
// of a vector is strobed on out_valid for one cycle, in input order; there is
// no way to hold results off, so the receiver must take each one when it
// appears. The pipeline is built from two bit-serial square-root pipelines
// (24 and 31 stages) and two 15-stage divider pipelines in series, plus the
// multiply and rounding stages. Write the reference direction only while no
// vector is in flight.
module vector_align_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic signed [15:0] in_vec_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic [15:0]        out_magnitude,
  output logic signed [15:0] out_m00,
  output logic signed [15:0] out_m01,
  output logic signed [15:0] out_m02,
  output logic signed [15:0] out_m10,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m20,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22
);

  localparam int L = vam_pkg::DIV_LANES;

  // Side data widths carried through the long units.
  localparam int SIDE1_W = 48;             // the input vector
  localparam int SIDE2_W = 20;             // magnitude, signs, zero flag
  localparam int SIDE3_W = 4 * 32 + 16 + 1;  // cross, dot, magnitude, identity
  localparam int SIDE4_W = 19 + 18 + 3 + 16 + 1;

  // Magnitude of a 16-bit two's complement value; -32768 gives 32768.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Clamp an unsigned quotient to 1.0 and apply the sign.
  function automatic logic signed [15:0] sat_sign(input logic [14:0] q,
                                                  input logic neg);
    logic [14:0] m;
    m = (q > 15'(vam_pkg::ONE_Q14)) ? 15'(vam_pkg::ONE_Q14) : q;
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Divide by 2^28, rounding halves away from zero, then clamp to +-1.0.
  function automatic logic signed [15:0] round_q28(input logic signed [49:0] acc);
    logic [49:0] m;
    logic [49:0] r;
    logic [14:0] q;
    m = acc[49] ? 50'(-acc) : 50'(acc);
    r = (m + 50'd134217728) >> 28;
    q = (r > 50'(vam_pkg::ONE_Q14)) ? 15'(vam_pkg::ONE_Q14) : 15'(r);
    return sat_sign(q, acc[49]);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers: the reference direction in Q1.14.
  // ---------------------------------------------------------------------
  logic signed [15:0] dir_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= 16'(vam_pkg::ONE_Q14);
    end else if (cfg_we) begin
      case (cfg_addr)
        vam_pkg::CFG_DIR_X: dir_r[0] <= cfg_wdata;
        vam_pkg::CFG_DIR_Y: dir_r[1] <= cfg_wdata;
        vam_pkg::CFG_DIR_Z: dir_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so every start is a transfer.
  assign busy = 1'b0;

  logic signed [15:0] in_v [3];
  assign in_v[0] = in_vec_x;
  assign in_v[1] = in_vec_y;
  assign in_v[2] = in_vec_z;

  // ---------------------------------------------------------------------
  // Stage 1: component squares.
  // ---------------------------------------------------------------------
  logic               s1_vld_r;
  logic signed [15:0] s1_v_r   [3];
  logic [30:0]        s1_sq_r  [3];
  logic [30:0]        s1_sq_nxt[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_sq_nxt[i] = 31'(32'(in_v[i]) * 32'(in_v[i]));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sum of squares.
  // ---------------------------------------------------------------------
  logic               s2_vld_r;
  logic signed [15:0] s2_v_r [3];
  logic [31:0]        s2_s_r;
  logic [31:0]        s2_s_nxt;

  assign s2_s_nxt = 32'(s1_sq_r[0]) + 32'(s1_sq_r[1]) + 32'(s1_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_v_r  <= in_v;
    s1_sq_r <= s1_sq_nxt;
    s2_v_r  <= s1_v_r;
    s2_s_r  <= s2_s_nxt;
  end

  // ---------------------------------------------------------------------
  // Length in Q8: floor(sqrt(s << 16)). Its integer part is floor(sqrt(s))
  // and its first fraction bit decides the rounding of the magnitude.
  // ---------------------------------------------------------------------
  logic               r1_vld;
  logic [23:0]        r1_root;
  logic [SIDE1_W-1:0] r1_side;

  vam_sqrt_pipe #(
    .RAD_W  (vam_pkg::SQ1_RAD_W),
    .SIDE_W (SIDE1_W)
  ) u_len_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .in_rad   ({s2_s_r, 16'd0}),
    .in_side  ({s2_v_r[0], s2_v_r[1], s2_v_r[2]}),
    .out_vld  (r1_vld),
    .out_root (r1_root),
    .out_side (r1_side)
  );

  // ---------------------------------------------------------------------
  // Stage 3: magnitude and dividends for normalizing. Each dividend holds
  // half the divisor so that the floor quotient rounds halves up.
  // ---------------------------------------------------------------------
  logic                                 s3_vld_r;
  logic [L-1:0][vam_pkg::DIV1_NUM_W-1:0] s3_num_r, s3_num_nxt;
  logic [23:0]                          s3_den_r;
  logic [L-1:0]                         s3_neg_r, s3_neg_nxt;
  logic                                 s3_zero_r, s3_zero_nxt;
  logic [15:0]                          s3_mag_r, s3_mag_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_neg_nxt[i] = r1_side[SIDE1_W-1-16*i];
      s3_num_nxt[i] = {abs16(r1_side[SIDE1_W-1-16*i -: 16]), 22'd0}
                    + 38'(r1_root[23:1]);
    end
    s3_mag_nxt  = r1_root[23:8] + 16'(r1_root[7]);
    s3_zero_nxt = (r1_root == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_num_r  <= s3_num_nxt;
    s3_den_r  <= r1_root;
    s3_neg_r  <= s3_neg_nxt;
    s3_zero_r <= s3_zero_nxt;
    s3_mag_r  <= s3_mag_nxt;
  end

  logic                            d1_vld;
  logic [L-1:0][vam_pkg::QUO_W-1:0] d1_quo;
  logic [SIDE2_W-1:0]              d1_side;

  vam_div_pipe #(
    .NUM_W  (vam_pkg::DIV1_NUM_W),
    .DEN_W  (vam_pkg::DIV1_DEN_W),
    .QUO_W  (vam_pkg::QUO_W),
    .LANES  (L),
    .SIDE_W (SIDE2_W)
  ) u_norm_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_num   (s3_num_r),
    .in_den   (s3_den_r),
    .in_side  ({s3_mag_r, s3_neg_r, s3_zero_r}),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // ---------------------------------------------------------------------
  // Stage 4: normalized vector n in Q1.14.
  // Stage 5: all nine products d_i * n_j.
  // Stage 6: cross product c = d x n and dot product p = d . n (Q28).
  // Stage 7: squares of the cross product components.
  // Stage 8: |c|^2 and the identity decision.
  // ---------------------------------------------------------------------
  logic               s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r, s8_vld_r;
  logic signed [15:0] s4_n_r [3];
  logic signed [15:0] s4_n_nxt [3];
  logic [15:0]        s4_mag_r, s5_mag_r, s6_mag_r, s7_mag_r, s8_mag_r;
  logic               s4_zero_r, s5_zero_r, s6_zero_r, s7_zero_r;
  logic signed [31:0] s5_dn_r [3][3];
  logic signed [31:0] s5_dn_nxt [3][3];
  logic signed [31:0] s6_c_r [3];
  logic signed [31:0] s6_c_nxt [3];
  logic signed [31:0] s6_p_r, s6_p_nxt;
  logic signed [31:0] s7_c_r [3];
  logic signed [31:0] s7_p_r;
  logic [60:0]        s7_csq_r [3];
  logic [60:0]        s7_csq_nxt [3];
  logic signed [31:0] s8_c_r [3];
  logic signed [31:0] s8_p_r;
  logic [61:0]        s8_sc_r, s8_sc_nxt;
  logic               s8_ident_r, s8_ident_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_n_nxt[i] = sat_sign(d1_quo[i], d1_side[1+i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s5_dn_nxt[i][j] = 32'(dir_r[i]) * 32'(s4_n_r[j]);
      end
    end
  end

  always_comb begin
    s6_c_nxt[0] = 32'(33'(s5_dn_r[1][2]) - 33'(s5_dn_r[2][1]));
    s6_c_nxt[1] = 32'(33'(s5_dn_r[2][0]) - 33'(s5_dn_r[0][2]));
    s6_c_nxt[2] = 32'(33'(s5_dn_r[0][1]) - 33'(s5_dn_r[1][0]));
    s6_p_nxt    = 32'(34'(s5_dn_r[0][0]) + 34'(s5_dn_r[1][1]) + 34'(s5_dn_r[2][2]));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s7_csq_nxt[i] = 61'(62'(31'(s6_c_r[i][31] ? -s6_c_r[i] : s6_c_r[i]))
                        * 62'(31'(s6_c_r[i][31] ? -s6_c_r[i] : s6_c_r[i])));
    end
  end

  // A sine that rounds to zero in Q1.14 gives the identity, as does a zero
  // vector.
  always_comb begin
    s8_sc_nxt    = 62'(s7_csq_r[0]) + 62'(s7_csq_r[1]) + 62'(s7_csq_r[2]);
    s8_ident_nxt = s7_zero_r | ~|s8_sc_nxt[61:vam_pkg::SIN_MIN_LOG2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= d1_vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_n_r     <= s4_n_nxt;
    s4_mag_r   <= d1_side[SIDE2_W-1 -: 16];
    s4_zero_r  <= d1_side[0];
    s5_dn_r    <= s5_dn_nxt;
    s5_mag_r   <= s4_mag_r;
    s5_zero_r  <= s4_zero_r;
    s6_c_r     <= s6_c_nxt;
    s6_p_r     <= s6_p_nxt;
    s6_mag_r   <= s5_mag_r;
    s6_zero_r  <= s5_zero_r;
    s7_c_r     <= s6_c_r;
    s7_p_r     <= s6_p_r;
    s7_csq_r   <= s7_csq_nxt;
    s7_mag_r   <= s6_mag_r;
    s7_zero_r  <= s6_zero_r;
    s8_c_r     <= s7_c_r;
    s8_p_r     <= s7_p_r;
    s8_sc_r    <= s8_sc_nxt;
    s8_mag_r   <= s7_mag_r;
    s8_ident_r <= s8_ident_nxt;
  end

  // ---------------------------------------------------------------------
  // Sine in Q28: floor(sqrt(|c|^2)).
  // ---------------------------------------------------------------------
  logic               r2_vld;
  logic [30:0]        r2_root;
  logic [SIDE3_W-1:0] r2_side;

  vam_sqrt_pipe #(
    .RAD_W  (vam_pkg::SQ2_RAD_W),
    .SIDE_W (SIDE3_W)
  ) u_sin_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s8_vld_r),
    .in_rad   (s8_sc_r),
    .in_side  ({s8_c_r[0], s8_c_r[1], s8_c_r[2], s8_p_r, s8_mag_r, s8_ident_r}),
    .out_vld  (r2_vld),
    .out_root (r2_root),
    .out_side (r2_side)
  );

  // ---------------------------------------------------------------------
  // Stage 9: cosine and sine in Q1.14, dividends for the rotation axis.
  // ---------------------------------------------------------------------
  logic                                 s9_vld_r;
  logic [L-1:0][vam_pkg::DIV2_NUM_W-1:0] s9_num_r, s9_num_nxt;
  logic [30:0]                          s9_den_r;
  logic [L-1:0]                         s9_neg_r, s9_neg_nxt;
  logic signed [18:0]                   s9_cos_r, s9_cos_nxt;
  logic [17:0]                          s9_sin_r, s9_sin_nxt;
  logic [15:0]                          s9_mag_r;
  logic                                 s9_ident_r;
  logic signed [31:0]                   r2_c [3];
  logic signed [31:0]                   r2_p;
  logic [31:0]                          r2_pabs;
  logic [17:0]                          r2_cos_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2_c[i]       = r2_side[SIDE3_W-1-32*i -: 32];
      s9_neg_nxt[i] = r2_c[i][31];
      s9_num_nxt[i] = {31'(r2_c[i][31] ? -r2_c[i] : r2_c[i]), 14'd0}
                    + 46'(r2_root[30:1]);
    end
    r2_p       = r2_side[48:17];
    r2_pabs    = r2_p[31] ? 32'(-r2_p) : 32'(r2_p);
    r2_cos_mag = 18'((33'(r2_pabs) + 33'd8192) >> 14);
    s9_cos_nxt = r2_p[31] ? -$signed({1'b0, r2_cos_mag}) : $signed({1'b0, r2_cos_mag});
    s9_sin_nxt = 18'((32'(r2_root) + 32'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s9_num_r   <= s9_num_nxt;
    s9_den_r   <= r2_root;
    s9_neg_r   <= s9_neg_nxt;
    s9_cos_r   <= s9_cos_nxt;
    s9_sin_r   <= s9_sin_nxt;
    s9_mag_r   <= r2_side[16:1];
    s9_ident_r <= r2_side[0];
  end

  logic                            d2_vld;
  logic [L-1:0][vam_pkg::QUO_W-1:0] d2_quo;
  logic [SIDE4_W-1:0]              d2_side;

  vam_div_pipe #(
    .NUM_W  (vam_pkg::DIV2_NUM_W),
    .DEN_W  (vam_pkg::DIV2_DEN_W),
    .QUO_W  (vam_pkg::QUO_W),
    .LANES  (L),
    .SIDE_W (SIDE4_W)
  ) u_axis_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s9_vld_r),
    .in_num   (s9_num_r),
    .in_den   (s9_den_r),
    .in_side  ({s9_cos_r, s9_sin_r, s9_neg_r, s9_mag_r, s9_ident_r}),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // ---------------------------------------------------------------------
  // Stage 10: axis a in Q1.14 and (1 - cos).
  // Stage 11: axis products a_i*a_j and sine terms a_k*sin.
  // Stage 12: a_i*a_j*(1 - cos).
  // Stage 13: Rodrigues sums in Q42.
  // Stage 14: rounding, clamping and the identity override.
  // ---------------------------------------------------------------------
  logic               s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r;
  logic signed [15:0] s10_a_r [3];
  logic signed [15:0] s10_a_nxt [3];
  logic signed [19:0] s10_one_r, s10_one_nxt, s11_one_r;
  logic signed [18:0] s10_cos_r, s11_cos_r, s12_cos_r;
  logic [17:0]        s10_sin_r;
  logic [15:0]        s10_mag_r, s11_mag_r, s12_mag_r, s13_mag_r;
  logic               s10_ident_r, s11_ident_r, s12_ident_r, s13_ident_r;
  logic signed [29:0] s11_aa_r [6];
  logic signed [29:0] s11_aa_nxt [6];
  logic signed [32:0] s11_t_r [3];
  logic signed [32:0] s11_t_nxt [3];
  logic signed [32:0] s12_t_r [3];
  logic signed [47:0] s12_pr_r [6];
  logic signed [47:0] s12_pr_nxt [6];
  logic signed [49:0] s13_acc_r [9];
  logic signed [49:0] s13_acc_nxt [9];
  logic signed [49:0] cos_q28;
  logic signed [49:0] t_q28 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_a_nxt[i] = sat_sign(d2_quo[i], d2_side[17+i]);
    end
    s10_one_nxt = 20'(vam_pkg::ONE_Q14) - 20'($signed(d2_side[SIDE4_W-1 -: 19]));
  end

  // Axis pair order: 00, 11, 22, 01, 02, 12.
  always_comb begin
    s11_aa_nxt[0] = 30'(32'(s10_a_r[0]) * 32'(s10_a_r[0]));
    s11_aa_nxt[1] = 30'(32'(s10_a_r[1]) * 32'(s10_a_r[1]));
    s11_aa_nxt[2] = 30'(32'(s10_a_r[2]) * 32'(s10_a_r[2]));
    s11_aa_nxt[3] = 30'(32'(s10_a_r[0]) * 32'(s10_a_r[1]));
    s11_aa_nxt[4] = 30'(32'(s10_a_r[0]) * 32'(s10_a_r[2]));
    s11_aa_nxt[5] = 30'(32'(s10_a_r[1]) * 32'(s10_a_r[2]));
    for (int k = 0; k < 3; k++) begin
      s11_t_nxt[k] = 33'(35'(s10_a_r[k]) * 35'($signed({1'b0, s10_sin_r})));
    end
  end

  always_comb begin
    for (int q = 0; q < 6; q++) begin
      s12_pr_nxt[q] = 48'(50'(s11_aa_r[q]) * 50'(s11_one_r));
    end
  end

  always_comb begin
    cos_q28 = 50'(s12_cos_r) <<< 28;
    for (int k = 0; k < 3; k++) begin
      t_q28[k] = 50'(s12_t_r[k]) <<< 14;
    end
    s13_acc_nxt[0] = 50'(s12_pr_r[0]) + cos_q28;
    s13_acc_nxt[1] = 50'(s12_pr_r[3]) - t_q28[2];
    s13_acc_nxt[2] = 50'(s12_pr_r[4]) + t_q28[1];
    s13_acc_nxt[3] = 50'(s12_pr_r[3]) + t_q28[2];
    s13_acc_nxt[4] = 50'(s12_pr_r[1]) + cos_q28;
    s13_acc_nxt[5] = 50'(s12_pr_r[5]) - t_q28[0];
    s13_acc_nxt[6] = 50'(s12_pr_r[4]) - t_q28[1];
    s13_acc_nxt[7] = 50'(s12_pr_r[5]) + t_q28[0];
    s13_acc_nxt[8] = 50'(s12_pr_r[2]) + cos_q28;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
    end else begin
      s10_vld_r <= d2_vld;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      s13_vld_r <= s12_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s10_a_r     <= s10_a_nxt;
    s10_one_r   <= s10_one_nxt;
    s10_cos_r   <= d2_side[SIDE4_W-1 -: 19];
    s10_sin_r   <= d2_side[37:20];
    s10_mag_r   <= d2_side[16:1];
    s10_ident_r <= d2_side[0];
    s11_aa_r    <= s11_aa_nxt;
    s11_t_r     <= s11_t_nxt;
    s11_one_r   <= s10_one_r;
    s11_cos_r   <= s10_cos_r;
    s11_mag_r   <= s10_mag_r;
    s11_ident_r <= s10_ident_r;
    s12_pr_r    <= s12_pr_nxt;
    s12_t_r     <= s11_t_r;
    s12_cos_r   <= s11_cos_r;
    s12_mag_r   <= s11_mag_r;
    s12_ident_r <= s11_ident_r;
    s13_acc_r   <= s13_acc_nxt;
    s13_mag_r   <= s12_mag_r;
    s13_ident_r <= s12_ident_r;
  end

  // Output registers; the diagonal of the row-major matrix sits at 0, 4, 8.
  logic               out_valid_r;
  logic [15:0]        out_mag_r;
  logic signed [15:0] out_m_r   [9];
  logic signed [15:0] out_m_nxt [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (s13_ident_r) begin
        out_m_nxt[k] = (k == 0 || k == 4 || k == 8) ? 16'(vam_pkg::ONE_Q14) : 16'sd0;
      end else begin
        out_m_nxt[k] = round_q28(s13_acc_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s13_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_mag_r <= s13_mag_r;
    out_m_r   <= out_m_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_m00       = out_m_r[0];
  assign out_m01       = out_m_r[1];
  assign out_m02       = out_m_r[2];
  assign out_m10       = out_m_r[3];
  assign out_m11       = out_m_r[4];
  assign out_m12       = out_m_r[5];
  assign out_m20       = out_m_r[6];
  assign out_m21       = out_m_r[7];
  assign out_m22       = out_m_r[8];

endmodule
